// File: rtl/scbc_pkg.sv
// Shared types, codes and the size class table of the size class bin cache.
package scbc_pkg;

	// Default geometry
	localparam int NUM_BINS_DEF         = 36;
	localparam int BIN_DEPTH_DEF        = 64;
	localparam int MEDIUM_FIRST_BIN_DEF = 8;
	localparam int LARGE_FIRST_BIN_DEF  = 16;
	localparam int XLARGE_FIRST_BIN_DEF = 28;
	localparam int CLASS_COUNT          = 36;

	// Register reset values
	localparam logic [13:0] MAX_SIZE_RST   = 14'd8192;
	localparam logic [6:0]  CAP_SMALL_RST  = 7'd64;
	localparam logic [6:0]  CAP_MEDIUM_RST = 7'd32;
	localparam logic [6:0]  CAP_LARGE_RST  = 7'd16;
	localparam logic [6:0]  CAP_XLARGE_RST = 7'd8;

	// Register indexes
	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_MAX_SIZE = 3'd1;
	localparam logic [2:0] REG_DISABLE  = 3'd2;
	localparam logic [2:0] REG_CAP_S    = 3'd3;
	localparam logic [2:0] REG_CAP_M    = 3'd4;
	localparam logic [2:0] REG_CAP_L    = 3'd5;
	localparam logic [2:0] REG_CAP_XL   = 3'd6;

	// Request kinds
	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_REFILL = 2'd2;
	localparam logic [1:0] REQ_DRAIN  = 2'd3;

	// Result status codes
	localparam logic [3:0] ST_ALLOCATED     = 4'd0;
	localparam logic [3:0] ST_CACHED        = 4'd1;
	localparam logic [3:0] ST_NOT_ELIGIBLE  = 4'd2;
	localparam logic [3:0] ST_REFILL_NEEDED = 4'd3;
	localparam logic [3:0] ST_FLUSHED       = 4'd4;
	localparam logic [3:0] ST_REFILL_OK     = 4'd5;
	localparam logic [3:0] ST_REFILL_FULL   = 4'd6;
	localparam logic [3:0] ST_DRAINED       = 4'd7;
	localparam logic [3:0] ST_EMPTY         = 4'd8;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_req;
		logic       map;
		logic       load_cnt;
		logic       rd_top;
		logic       rd_bot;
		logic       push;
		logic       cnt_clear;
		logic       emit;
		logic       emit_last;
		logic [3:0] emit_st;
	} scbc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] req_type;
		logic       elig;
		logic       n_zero;
		logic       full;
		logic       f_zero;
		logic       drain_end;
		logic       out_free;
	} scbc_stat_t;

	// Byte size of each class; padding classes and unused bins are zero
	function automatic logic [13:0] class_bytes(input logic [5:0] b);
		logic [13:0] v;
		case (b)
			6'd0:  v = 14'd8;
			6'd1:  v = 14'd16;
			6'd2:  v = 14'd32;
			6'd3:  v = 14'd48;
			6'd4:  v = 14'd64;
			6'd5:  v = 14'd80;
			6'd6:  v = 14'd96;
			6'd7:  v = 14'd112;
			6'd8:  v = 14'd128;
			6'd9:  v = 14'd160;
			6'd10: v = 14'd192;
			6'd11: v = 14'd224;
			6'd12: v = 14'd256;
			6'd13: v = 14'd320;
			6'd14: v = 14'd384;
			6'd15: v = 14'd448;
			6'd16: v = 14'd512;
			6'd17: v = 14'd640;
			6'd18: v = 14'd768;
			6'd19: v = 14'd896;
			6'd20: v = 14'd1024;
			6'd21: v = 14'd1280;
			6'd22: v = 14'd1536;
			6'd23: v = 14'd1792;
			6'd24: v = 14'd2048;
			6'd28: v = 14'd2560;
			6'd29: v = 14'd3072;
			6'd30: v = 14'd3584;
			6'd31: v = 14'd4096;
			6'd32: v = 14'd5120;
			6'd33: v = 14'd6144;
			6'd34: v = 14'd7168;
			6'd35: v = 14'd8192;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/size_class_bin_cache.sv
// Top level of the size class bin cache: stream ports, controller and datapath.
// A request that yields one result passes from acceptance to its result word through the
// steps accept, size-class match, count load, decision and result. A flush adds a read and
// an emit per flushed handle plus a step to recheck the bin; a drain reads and emits each
// handle in turn. Both are set by the single-port stack memory whose read data
// is registered before it reaches the output word, and a stalled output word holds the
// item for as long as it waits. The stack memory holds
// NUM_BINS * 2**ceil(log2(BIN_DEPTH)) handles and needs no clearing pass: only entries
// below a bin's count are read. Bin counts sit in a small memory read while the size is
// mapped, with one written flag per bin cleared at reset. A new request is taken only once
// the previous one has placed its final result in the output register; that word may still
// wait there.
module size_class_bin_cache #(
	parameter int NUM_BINS         = scbc_pkg::NUM_BINS_DEF,
	parameter int BIN_DEPTH        = scbc_pkg::BIN_DEPTH_DEF,
	parameter int MEDIUM_FIRST_BIN = scbc_pkg::MEDIUM_FIRST_BIN_DEF,
	parameter int LARGE_FIRST_BIN  = scbc_pkg::LARGE_FIRST_BIN_DEF,
	parameter int XLARGE_FIRST_BIN = scbc_pkg::XLARGE_FIRST_BIN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [35:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // req_size[15:0], buf_handle[79:16]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // out_handle[63:0], bin_index[69:64], refill_want[75:70]
	output logic [3:0]  m_axis_tuser,  // status[3:0]
	output logic        m_axis_tlast
);

	scbc_pkg::scbc_cmd_t  cmd;
	scbc_pkg::scbc_stat_t stat;

	scbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scbc_datapath #(
		.NUM_BINS         (NUM_BINS),
		.BIN_DEPTH        (BIN_DEPTH),
		.MEDIUM_FIRST_BIN (MEDIUM_FIRST_BIN),
		.LARGE_FIRST_BIN  (LARGE_FIRST_BIN),
		.XLARGE_FIRST_BIN (XLARGE_FIRST_BIN)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (s_axis_tuser),
		.req_data   (s_axis_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_last   (m_axis_tlast),
		.out_data   (m_axis_tdata)
	);

endmodule

// File: rtl/scbc_datapath.sv
// Datapath of the size class bin cache: registers, bin mapping, counts, stack memory, output.
module scbc_datapath #(
	parameter int NUM_BINS         = scbc_pkg::NUM_BINS_DEF,
	parameter int BIN_DEPTH        = scbc_pkg::BIN_DEPTH_DEF,
	parameter int MEDIUM_FIRST_BIN = scbc_pkg::MEDIUM_FIRST_BIN_DEF,
	parameter int LARGE_FIRST_BIN  = scbc_pkg::LARGE_FIRST_BIN_DEF,
	parameter int XLARGE_FIRST_BIN = scbc_pkg::XLARGE_FIRST_BIN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [35:0]         cfg_data,
	input  logic [1:0]          req_type,
	input  logic [79:0]         req_data,
	input  scbc_pkg::scbc_cmd_t cmd,
	output scbc_pkg::scbc_stat_t stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          out_status,
	output logic                out_last,
	output logic [79:0]         out_data
);

	localparam int IW = $clog2(BIN_DEPTH);
	localparam int CW = $clog2(BIN_DEPTH + 1);
	localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int MEM_DEPTH = NUM_BINS * (2 ** IW);

	// Configuration registers
	logic        enable_q;
	logic [13:0] max_size_q;
	logic [35:0] disable_q;
	logic [6:0]  cap_s_q, cap_m_q, cap_l_q, cap_xl_q;

	// Request and per-item working registers
	logic [1:0]    type_q;
	logic [15:0]   size_q;
	logic [63:0]   handle_q;
	logic [5:0]    bin_q;
	logic          elig_q;
	logic [CW-1:0] n_q, cap_q, f_q, i_q;
	logic [63:0]   rdata_q;

	// Count memory, its read data and per-bin written flags
	logic [CW-1:0]       cnt_q [NUM_BINS];
	logic [NUM_BINS-1:0] cnt_vld_q;
	logic [CW-1:0]       cnt_rd_q;
	logic                cnt_vld_rd_q;
	logic [63:0]         mem [MEM_DEPTH];

	// Output register
	logic        out_valid_q;
	logic [3:0]  out_st_q;
	logic        out_last_q;
	logic [63:0] out_handle_q;
	logic [5:0]  out_bin_q;
	logic [5:0]  out_refill_q;

	logic [16:0]   rounded;
	logic          hit;
	logic [5:0]    bsel;
	logic [BW-1:0] bsel_idx;
	logic [BW-1:0] bidx;
	logic [CW-1:0] n_dec;
	logic [6:0]    cap_raw;
	logic [6:0]    cap_clamp;
	logic [CW-1:0] cnt_cur;
	logic [CW-1:0] half;
	logic          out_free;

	assign bidx     = bin_q[BW-1:0];
	assign bsel_idx = bsel[BW-1:0];
	assign n_dec    = n_q - CW'(1);

	// Round the size up to 8 and search the class table
	always_comb begin
		rounded = ({1'b0, size_q} + 17'd7) & ~17'd7;
		hit     = 1'b0;
		bsel    = 6'd0;
		for (int b = 0; b < scbc_pkg::CLASS_COUNT; b++) begin
			if (b < NUM_BINS && !hit && rounded != 17'd0 &&
			    {3'b000, scbc_pkg::class_bytes(6'(b))} == rounded) begin
				hit  = 1'b1;
				bsel = 6'(b);
			end
		end
	end

	// Pick the tier capacity and clamp it between 2 and the stack depth
	always_comb begin
		if ({1'b0, bin_q} < 7'(MEDIUM_FIRST_BIN))
			cap_raw = cap_s_q;
		else if ({1'b0, bin_q} < 7'(LARGE_FIRST_BIN))
			cap_raw = cap_m_q;
		else if ({1'b0, bin_q} < 7'(XLARGE_FIRST_BIN))
			cap_raw = cap_l_q;
		else
			cap_raw = cap_xl_q;
		if (cap_raw < 7'd2)
			cap_clamp = 7'd2;
		else if (cap_raw > 7'(BIN_DEPTH))
			cap_clamp = 7'(BIN_DEPTH);
		else
			cap_clamp = cap_raw;
	end

	// A bin never written since reset holds no handles
	assign cnt_cur = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign half    = cnt_cur >> 1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			max_size_q <= scbc_pkg::MAX_SIZE_RST;
			disable_q  <= '0;
			cap_s_q    <= scbc_pkg::CAP_SMALL_RST;
			cap_m_q    <= scbc_pkg::CAP_MEDIUM_RST;
			cap_l_q    <= scbc_pkg::CAP_LARGE_RST;
			cap_xl_q   <= scbc_pkg::CAP_XLARGE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				scbc_pkg::REG_ENABLE:   enable_q   <= cfg_data[0];
				scbc_pkg::REG_MAX_SIZE: max_size_q <= cfg_data[13:0];
				scbc_pkg::REG_DISABLE:  disable_q  <= cfg_data;
				scbc_pkg::REG_CAP_S:    cap_s_q    <= cfg_data[6:0];
				scbc_pkg::REG_CAP_M:    cap_m_q    <= cfg_data[6:0];
				scbc_pkg::REG_CAP_L:    cap_l_q    <= cfg_data[6:0];
				scbc_pkg::REG_CAP_XL:   cap_xl_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Latch the request, map it and load the bin's count
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q   <= req_type;
			size_q   <= req_data[15:0];
			handle_q <= req_data[79:16];
		end
		if (cmd.map) begin
			cnt_vld_rd_q <= cnt_vld_q[bsel_idx];
			if (enable_q && {2'b00, max_size_q} >= size_q && hit && !disable_q[bsel] &&
			    !(type_q == scbc_pkg::REQ_FREE && handle_q == 64'd0)) begin
				elig_q <= 1'b1;
				bin_q  <= bsel;
			end else begin
				elig_q <= 1'b0;
				bin_q  <= 6'd0;
			end
		end
		if (cmd.load_cnt) begin
			n_q   <= cnt_cur;
			cap_q <= CW'(cap_clamp);
			f_q   <= (half == '0) ? cnt_cur : half;
			i_q   <= '0;
		end
		if (cmd.rd_top) begin
			n_q <= n_dec;
			f_q <= f_q - CW'(1);
		end
		if (cmd.rd_bot)
			i_q <= i_q + CW'(1);
	end

	// Bin counts: one registered read while mapping, one write a cycle
	always_ff @(posedge clk) begin
		if (cmd.map)
			cnt_rd_q <= cnt_q[bsel_idx];
		if (cmd.rd_top)
			cnt_q[bidx] <= n_dec;
		else if (cmd.push)
			cnt_q[bidx] <= n_q + CW'(1);
		else if (cmd.cnt_clear)
			cnt_q[bidx] <= '0;
	end

	// Mark a bin's count as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_vld_q <= '0;
		else if (cmd.rd_top || cmd.push || cmd.cnt_clear)
			cnt_vld_q[bidx] <= 1'b1;
	end

	// Stack memory: one write or one read a cycle, read data registered
	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[{bidx, n_q[IW-1:0]}] <= handle_q;
		if (cmd.rd_top)
			rdata_q <= mem[{bidx, n_dec[IW-1:0]}];
		else if (cmd.rd_bot)
			rdata_q <= mem[{bidx, i_q[IW-1:0]}];
	end

	assign out_free = !out_valid_q || out_ready;

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_st_q   <= cmd.emit_st;
			out_last_q <= cmd.emit_last;
			out_handle_q <= (cmd.emit_st == scbc_pkg::ST_ALLOCATED ||
			                 cmd.emit_st == scbc_pkg::ST_FLUSHED ||
			                 cmd.emit_st == scbc_pkg::ST_DRAINED) ? rdata_q : 64'd0;
			out_bin_q <= (cmd.emit_st == scbc_pkg::ST_NOT_ELIGIBLE) ? 6'd0 : bin_q;
			out_refill_q <= (cmd.emit_st == scbc_pkg::ST_REFILL_NEEDED) ?
			                6'(cap_q >> 1) : 6'd0;
		end
	end

	assign stat.req_type  = type_q;
	assign stat.elig      = elig_q;
	assign stat.n_zero    = (n_q == '0);
	assign stat.full      = (n_q >= cap_q);
	assign stat.f_zero    = (f_q == '0);
	assign stat.drain_end = (i_q == n_q);
	assign stat.out_free  = out_free;

	assign out_valid  = out_valid_q;
	assign out_status = out_st_q;
	assign out_last   = out_last_q;
	assign out_data   = {4'd0, out_refill_q, out_bin_q, out_handle_q};

endmodule

// File: rtl/scbc_ctrl.sv
// Controller state machine of the size class bin cache.
module scbc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  scbc_pkg::scbc_stat_t stat,
	output scbc_pkg::scbc_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_MAP     = 4'd1;
	localparam logic [3:0] S_LOAD    = 4'd2;
	localparam logic [3:0] S_SEL     = 4'd3;
	localparam logic [3:0] S_NE      = 4'd4;
	localparam logic [3:0] S_RN      = 4'd5;
	localparam logic [3:0] S_AL      = 4'd6;
	localparam logic [3:0] S_RFULL   = 4'd7;
	localparam logic [3:0] S_EMPTY   = 4'd8;
	localparam logic [3:0] S_CACHED  = 4'd9;
	localparam logic [3:0] S_REFOK   = 4'd10;
	localparam logic [3:0] S_FL_RD   = 4'd11;
	localparam logic [3:0] S_FL_EM   = 4'd12;
	localparam logic [3:0] S_FL_END  = 4'd13;
	localparam logic [3:0] S_DR_RD   = 4'd14;
	localparam logic [3:0] S_DR_EM   = 4'd15;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_req = in_valid;
				if (in_valid)
					state_d = S_MAP;
			end
			S_MAP: begin
				cmd.map = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_cnt = 1'b1;
				state_d      = S_SEL;
			end
			S_SEL: begin
				if (!stat.elig)
					state_d = S_NE;
				else begin
					case (stat.req_type)
						scbc_pkg::REQ_ALLOC: begin
							if (stat.n_zero)
								state_d = S_RN;
							else begin
								cmd.rd_top = 1'b1;
								state_d    = S_AL;
							end
						end
						scbc_pkg::REQ_FREE:
							state_d = stat.full ? S_FL_RD : S_CACHED;
						scbc_pkg::REQ_REFILL:
							state_d = stat.full ? S_RFULL : S_REFOK;
						default:
							state_d = stat.n_zero ? S_EMPTY : S_DR_RD;
					endcase
				end
			end
			S_FL_RD: begin
				cmd.rd_top = 1'b1;
				state_d    = S_FL_EM;
			end
			S_FL_EM: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.emit_st = scbc_pkg::ST_FLUSHED;
					state_d     = stat.f_zero ? S_FL_END : S_FL_RD;
				end
			end
			S_FL_END:
				state_d = stat.full ? S_NE : S_CACHED;
			S_DR_RD: begin
				cmd.rd_bot = 1'b1;
				state_d    = S_DR_EM;
			end
			S_DR_EM: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_st   = scbc_pkg::ST_DRAINED;
					cmd.emit_last = stat.drain_end;
					cmd.cnt_clear = stat.drain_end;
					state_d       = stat.drain_end ? S_IDLE : S_DR_RD;
				end
			end
			default: begin
				// Single final result states
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
					case (state_q)
						S_NE:     cmd.emit_st = scbc_pkg::ST_NOT_ELIGIBLE;
						S_RN:     cmd.emit_st = scbc_pkg::ST_REFILL_NEEDED;
						S_AL:     cmd.emit_st = scbc_pkg::ST_ALLOCATED;
						S_RFULL:  cmd.emit_st = scbc_pkg::ST_REFILL_FULL;
						S_EMPTY:  cmd.emit_st = scbc_pkg::ST_EMPTY;
						S_CACHED: begin
							cmd.emit_st = scbc_pkg::ST_CACHED;
							cmd.push    = 1'b1;
						end
						S_REFOK: begin
							cmd.emit_st = scbc_pkg::ST_REFILL_OK;
							cmd.push    = 1'b1;
						end
						default: cmd.emit_st = scbc_pkg::ST_NOT_ELIGIBLE;
					endcase
				end
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Never overwrite a waiting output word
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> stat.out_free)
		else $error("emit while output word is held");

	// Never push onto a full bin
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> !stat.full)
		else $error("push onto a full bin");

	// An accepted request goes straight to mapping
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && in_valid) |=> (state_q == S_MAP))
		else $error("accepted request not mapped");

	// Only one stack access per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.rd_top, cmd.rd_bot, cmd.push}) <= 1)
		else $error("more than one stack access in a cycle");

endmodule
